// ----- rtl/core/iwsa_pkg.sv -----
// Shared types, codes and constants of the I/O window slot allocator.
// No dependencies; every other file of the block but iwsa_ram imports this package.
package iwsa_pkg;

   // Default values of the top-level parameters.
   localparam int PAGE_SHIFT_DEF            = 12;
   localparam int SMALL_SLOTS_DEF           = 512;
   localparam int LARGE_SLOTS_DEF           = 16;
   localparam int LARGE_SLOT_PAGE_SHIFT_DEF = 6;

   // Fixed field widths.
   localparam int ADDR_W     = 64;
   localparam int PHYS_W     = 52;
   localparam int LEN_W      = 32;
   localparam int SPAN_W     = 34;
   localparam int SPAN_OUT_W = 19;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 152;

   // Bitmap memory word: 32 slot bits per row.
   localparam int WORD_W = 32;
   localparam int LANE_W = 5;

   localparam logic [ADDR_W-1:0] WINDOW_BASE_RESET = 64'hFFFF_FFFF_FFA0_0000;

   typedef enum logic {
      KIND_MAP   = 1'b0,
      KIND_UNMAP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_SPACE  = 2'd1,
      STAT_BAD_UNMAP = 2'd2
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sum;
      logic              cout;
   } alu_res_type;

   typedef struct packed {
      logic              found;
      logic [LANE_W-1:0] lane;
   } scan_res_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPAN_SUM,
      ST_SPAN_ROUND,
      ST_LBASE,
      ST_SCAN,
      ST_VA_SLOT,
      ST_VA_OFF,
      ST_UN_CMP,
      ST_UN_DIFF,
      ST_UN_READ,
      ST_UN_WRITE,
      ST_DONE
   } state_type;

   // Mask with the lowest n bits set.
   function automatic logic [WORD_W-1:0] low_mask(input int n);
      logic [WORD_W-1:0] m;
      for (int i = 0; i < WORD_W; i++) begin
         m[i] = (i < n);
      end
      return m;
   endfunction

endpackage

// ----- rtl/core/iwsa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the slot bitmaps of the allocator.
module iwsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/iwsa_alu.sv -----
// Shared 64-bit adder/subtractor of the allocator sequencer.
// Depends on iwsa_pkg for the operation code and result struct.
module iwsa_alu
   import iwsa_pkg::*;
(
   input  alu_op_type        op,
   input  logic [ADDR_W-1:0] a,
   input  logic [ADDR_W-1:0] b,
   output alu_res_type       res
);

   logic [ADDR_W-1:0] b_eff;
   logic              cin;
   logic [ADDR_W:0]   total;

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            b_eff = b;
            cin   = 1'b0;
         end
         ALU_SUB: begin
            b_eff = ~b;
            cin   = 1'b1;
         end
         default: begin
            b_eff = b;
            cin   = 1'b0;
         end
      endcase
      total = {1'b0, a} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, cin};
   end

   // On a subtract, a clear carry out means a < b.
   assign res.sum  = total[ADDR_W-1:0];
   assign res.cout = total[ADDR_W];

endmodule

// ----- rtl/core/iwsa_scan.sv -----
// Free-slot finder: lowest clear bit of one bitmap word among valid lanes.
// Depends on iwsa_pkg for the word width and the result struct.
module iwsa_scan
   import iwsa_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic [WORD_W-1:0] lane_valid,
   output scan_res_type      res
);

   logic [WORD_W-1:0] free_lanes;

   always_comb begin
      free_lanes = ~word & lane_valid;
      res.found  = |free_lanes;
      res.lane   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_lanes[i]) begin
            res.lane = LANE_W'(i);
         end
      end
   end

endmodule

// ----- rtl/core/io_window_slot_allocator_core.sv -----
// Top level of the I/O window slot allocator: sequencer, registers, ports.
// Depends on iwsa_pkg, iwsa_ram, iwsa_alu and iwsa_scan.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  req_    | in        | req_tvalid / req_tready | req_tuser kind, req_tdata fields
//  rsp_    | out       | rsp_tvalid / rsp_tready | rsp_tdata result fields
//  csr_    | in        | csr_valid / csr_ready   | csr_data = window_base
//
// An unmap runs ST_SPAN_SUM, ST_SPAN_ROUND, ST_LBASE, ST_UN_CMP, ST_UN_DIFF, ST_UN_READ
// and ST_UN_WRITE before ST_DONE. A map runs the same first three states, then ST_SCAN,
// which reads bitmap rows until a free slot turns up (moving on to the large pool when the
// small pool is exhausted), then ST_VA_SLOT and ST_VA_OFF before ST_DONE. The single bitmap
// RAM read port, one 32-bit row per cycle, sets the scan length. Errors skip to ST_DONE.
// After reset a clearing pass writes every bitmap row to zero, one row per cycle
// (SMALL_SLOTS/32 + LARGE_SLOTS/32 rows, rounded up: 17 rows by default); no
// request beat is taken during it. The response sits in an output register, so the
// next request is accepted while an earlier response is still stalled.
module io_window_slot_allocator_core
   import iwsa_pkg::*;
#(
   parameter int PAGE_SHIFT            = PAGE_SHIFT_DEF,
   parameter int SMALL_SLOTS           = SMALL_SLOTS_DEF,
   parameter int LARGE_SLOTS           = LARGE_SLOTS_DEF,
   parameter int LARGE_SLOT_PAGE_SHIFT = LARGE_SLOT_PAGE_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // kind (0 map, 1 unmap)
   // phys_addr [51:0], length [83:52], virt_addr [147:84], zero pad [151:148]
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status [1:0], result_addr [65:2], span_base [129:66],
   // span_length [148:130], zero pad [151:149]
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ADDR_W-1:0]     csr_data     // window_base
);

   // Geometry of the bitmap memory: small pool rows first, large pool rows after.
   localparam int LARGE_SHIFT = PAGE_SHIFT + LARGE_SLOT_PAGE_SHIFT;
   localparam int SMALL_ROWS  = (SMALL_SLOTS + WORD_W - 1) / WORD_W;
   localparam int LARGE_ROWS  = (LARGE_SLOTS + WORD_W - 1) / WORD_W;
   localparam int TOT_ROWS    = SMALL_ROWS + LARGE_ROWS;
   localparam int ROW_W       = $clog2(TOT_ROWS);
   localparam int CNT_W       = $clog2(TOT_ROWS + 1);
   localparam int SLOT_W      = ROW_W + LANE_W;
   localparam int SMALL_TAIL  = SMALL_SLOTS - (SMALL_ROWS - 1) * WORD_W;
   localparam int LARGE_TAIL  = LARGE_SLOTS - (LARGE_ROWS - 1) * WORD_W;

   localparam logic [WORD_W-1:0] SMALL_TAIL_MASK = low_mask(SMALL_TAIL);
   localparam logic [WORD_W-1:0] LARGE_TAIL_MASK = low_mask(LARGE_TAIL);

   localparam logic [ADDR_W-1:0] PAGE_MASK64  = (64'd1 << PAGE_SHIFT) - 64'd1;
   localparam logic [ADDR_W-1:0] SMALL_BYTES  = 64'(SMALL_SLOTS) << PAGE_SHIFT;
   localparam logic [ADDR_W-1:0] LARGE_REGION = 64'(LARGE_SLOTS) << LARGE_SHIFT;
   localparam logic [SPAN_W-1:0] PAGE_BYTES_S = SPAN_W'(1) << PAGE_SHIFT;
   localparam logic [SPAN_W-1:0] LARGE_BYTES_S = SPAN_W'(1) << LARGE_SHIFT;

   localparam logic [ROW_W-1:0] SMALL_LAST  = ROW_W'(SMALL_ROWS - 1);
   localparam logic [ROW_W-1:0] LARGE_FIRST = ROW_W'(SMALL_ROWS);
   localparam logic [ROW_W-1:0] LARGE_LAST  = ROW_W'(TOT_ROWS - 1);
   localparam logic [CNT_W-1:0] SMALL_END   = CNT_W'(SMALL_ROWS);
   localparam logic [CNT_W-1:0] LARGE_BEGIN = CNT_W'(SMALL_ROWS);
   localparam logic [CNT_W-1:0] LARGE_END   = CNT_W'(TOT_ROWS);
   localparam logic [CNT_W-1:0] CLEAR_LAST  = CNT_W'(TOT_ROWS - 1);

   // Sequencer and working registers.
   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;       // phys_addr for a map, virt_addr for an unmap
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [ADDR_W-1:0] lbase_ff, lbase_in;     // start of the large region
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic              pool_large_ff, pool_large_in;
   logic [CNT_W-1:0]  scan_row_ff, scan_row_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [ROW_W-1:0]  chk_row_ff, chk_row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              in_small_ff, in_small_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic [LANE_W-1:0] clr_lane_ff, clr_lane_in;
   status_type        stat_ff, stat_in;
   logic [ADDR_W-1:0] window_base_ff, window_base_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_result_addr_ff, rsp_result_addr_in;
   logic [ADDR_W-1:0]     rsp_span_base_ff, rsp_span_base_in;
   logic [SPAN_OUT_W-1:0] rsp_span_length_ff, rsp_span_length_in;

   // Shared units.
   alu_op_type        alu_op;
   logic [ADDR_W-1:0] alu_a;
   logic [ADDR_W-1:0] alu_b;
   alu_res_type       alu_res;
   logic [WORD_W-1:0] scan_valid;
   scan_res_type      scan_res;

   logic              ram_wr_en;
   logic [ROW_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ROW_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // Helpers derived from the working registers.
   logic [ADDR_W-1:0] page_off;
   logic [ADDR_W-1:0] page_base;
   logic              small_ok;
   logic              large_ok;
   logic [ROW_W-1:0]  local_row;
   logic [CNT_W-1:0]  scan_end;
   logic              chk_last;
   logic [ADDR_W-1:0] diff_slot;
   logic [SLOT_W-1:0] un_slot;
   logic              un_err;
   logic              rsp_load;

   iwsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TOT_ROWS),
      .AW    (ROW_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   iwsa_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   iwsa_scan u_scan (
      .word       (ram_rd_data),
      .lane_valid (scan_valid),
      .res        (scan_res)
   );

   assign page_off  = addr_ff & PAGE_MASK64;
   assign page_base = addr_ff & ~PAGE_MASK64;
   assign small_ok  = (span_ff <= PAGE_BYTES_S);
   assign large_ok  = (span_ff <= LARGE_BYTES_S);
   assign local_row = chk_row_ff - (pool_large_ff ? LARGE_FIRST : '0);
   assign scan_end  = pool_large_ff ? LARGE_END : SMALL_END;
   assign chk_last  = pool_large_ff ? (chk_row_ff == LARGE_LAST) : (chk_row_ff == SMALL_LAST);

   // Lanes past the end of a pool read as taken.
   always_comb begin
      if (chk_last) begin
         scan_valid = pool_large_ff ? LARGE_TAIL_MASK : SMALL_TAIL_MASK;
      end else begin
         scan_valid = '1;
      end
   end

   // Unmap slot decode from the offset into its region (ALU result in ST_UN_DIFF).
   assign diff_slot = in_small_ff ? (alu_res.sum >> PAGE_SHIFT) : (alu_res.sum >> LARGE_SHIFT);
   assign un_slot   = diff_slot[SLOT_W-1:0];
   assign un_err    = in_small_ff ?
                      (!alu_res.cout || (span_ff > PAGE_BYTES_S) || (alu_res.sum >= SMALL_BYTES)) :
                      ((span_ff > LARGE_BYTES_S) || (alu_res.sum >= LARGE_REGION));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      addr_in        = addr_ff;
      len_in         = len_ff;
      span_in        = span_ff;
      lbase_in       = lbase_ff;
      acc_in         = acc_ff;
      pool_large_in  = pool_large_ff;
      scan_row_in    = scan_row_ff;
      chk_vld_in     = 1'b0;
      chk_row_in     = chk_row_ff;
      slot_in        = slot_ff;
      in_small_in    = in_small_ff;
      clr_row_in     = clr_row_ff;
      clr_lane_in    = clr_lane_ff;
      stat_in        = stat_ff;
      window_base_in = window_base_ff;

      alu_op = ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;

      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_row_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = clr_row_ff;

      if (csr_valid && csr_ready) begin
         window_base_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_row_ff[ROW_W-1:0];
            ram_wr_data = '0;
            scan_row_in = scan_row_ff + CNT_W'(1);
            if (scan_row_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = kind_type'(req_tuser);
               len_in   = req_tdata[PHYS_W +: LEN_W];
               if (kind_type'(req_tuser) == KIND_MAP) begin
                  addr_in = ADDR_W'(req_tdata[PHYS_W-1:0]);
               end else begin
                  addr_in = req_tdata[PHYS_W + LEN_W +: ADDR_W];
               end
               state_in = ST_SPAN_SUM;
            end
         end

         ST_SPAN_SUM: begin
            alu_a    = ADDR_W'(len_ff);
            alu_b    = page_off;
            acc_in   = alu_res.sum;
            state_in = ST_SPAN_ROUND;
         end

         ST_SPAN_ROUND: begin
            alu_a    = acc_ff;
            alu_b    = PAGE_MASK64;
            span_in  = alu_res.sum[SPAN_W-1:0] & ~PAGE_MASK64[SPAN_W-1:0];
            state_in = ST_LBASE;
         end

         ST_LBASE: begin
            alu_a    = window_base_ff;
            alu_b    = SMALL_BYTES;
            lbase_in = alu_res.sum;
            if (kind_ff == KIND_UNMAP) begin
               state_in = ST_UN_CMP;
            end else if (small_ok) begin
               pool_large_in = 1'b0;
               scan_row_in   = '0;
               state_in      = ST_SCAN;
            end else if (large_ok) begin
               pool_large_in = 1'b1;
               scan_row_in   = LARGE_BEGIN;
               state_in      = ST_SCAN;
            end else begin
               stat_in  = STAT_NO_SPACE;
               state_in = ST_DONE;
            end
         end

         ST_SCAN: begin
            // Issue one row read per cycle; check the row read in the cycle before.
            if (scan_row_ff != scan_end) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_row_ff[ROW_W-1:0];
               scan_row_in = scan_row_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
               chk_row_in  = scan_row_ff[ROW_W-1:0];
            end
            if (chk_vld_ff) begin
               if (scan_res.found) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = chk_row_ff;
                  ram_wr_data = ram_rd_data | (WORD_W'(1) << scan_res.lane);
                  slot_in     = {local_row, scan_res.lane};
                  chk_vld_in  = 1'b0;
                  state_in    = ST_VA_SLOT;
               end else if (chk_last) begin
                  chk_vld_in = 1'b0;
                  if (!pool_large_ff && large_ok) begin
                     // Small pool exhausted: retry in the large pool.
                     pool_large_in = 1'b1;
                     scan_row_in   = LARGE_BEGIN;
                  end else begin
                     stat_in  = STAT_NO_SPACE;
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_VA_SLOT: begin
            alu_a    = pool_large_ff ? lbase_ff : window_base_ff;
            alu_b    = pool_large_ff ? (ADDR_W'(slot_ff) << LARGE_SHIFT) :
                                       (ADDR_W'(slot_ff) << PAGE_SHIFT);
            acc_in   = alu_res.sum;
            state_in = ST_VA_OFF;
         end

         ST_VA_OFF: begin
            alu_a    = acc_ff;
            alu_b    = page_off;
            acc_in   = alu_res.sum;
            stat_in  = STAT_OK;
            state_in = ST_DONE;
         end

         ST_UN_CMP: begin
            alu_op      = ALU_SUB;
            alu_a       = page_base;
            alu_b       = lbase_ff;
            in_small_in = !alu_res.cout;
            state_in    = ST_UN_DIFF;
         end

         ST_UN_DIFF: begin
            alu_op      = ALU_SUB;
            alu_a       = page_base;
            alu_b       = in_small_ff ? window_base_ff : lbase_ff;
            clr_row_in  = un_slot[SLOT_W-1:LANE_W] + (in_small_ff ? '0 : LARGE_FIRST);
            clr_lane_in = un_slot[LANE_W-1:0];
            if (un_err) begin
               stat_in  = STAT_BAD_UNMAP;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UN_READ;
            end
         end

         ST_UN_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = clr_row_ff;
            state_in    = ST_UN_WRITE;
         end

         ST_UN_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_row_ff;
            ram_wr_data = ram_rd_data & ~(WORD_W'(1) << clr_lane_ff);
            alu_a       = page_base;
            alu_b       = ADDR_W'(span_ff);
            acc_in      = alu_res.sum;
            stat_in     = STAT_OK;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loads in ST_DONE once the previous beat has gone or is being taken.
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      rsp_status_in      = rsp_status_ff;
      rsp_result_addr_in = rsp_result_addr_ff;
      rsp_span_base_in   = rsp_span_base_ff;
      rsp_span_length_in = rsp_span_length_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = stat_ff;
         if (stat_ff == STAT_OK) begin
            rsp_result_addr_in = acc_ff;
            rsp_span_base_in   = page_base;
            rsp_span_length_in = span_ff[SPAN_OUT_W-1:0];
         end else begin
            rsp_result_addr_in = '0;
            rsp_span_base_in   = '0;
            rsp_span_length_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         scan_row_ff    <= '0;
         chk_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         window_base_ff <= WINDOW_BASE_RESET;
      end else begin
         state_ff       <= state_in;
         scan_row_ff    <= scan_row_in;
         chk_vld_ff     <= chk_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         window_base_ff <= window_base_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff            <= kind_in;
      addr_ff            <= addr_in;
      len_ff             <= len_in;
      span_ff            <= span_in;
      lbase_ff           <= lbase_in;
      acc_ff             <= acc_in;
      pool_large_ff      <= pool_large_in;
      chk_row_ff         <= chk_row_in;
      slot_ff            <= slot_in;
      in_small_ff        <= in_small_in;
      clr_row_ff         <= clr_row_in;
      clr_lane_ff        <= clr_lane_in;
      stat_ff            <= stat_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_result_addr_ff <= rsp_result_addr_in;
      rsp_span_base_ff   <= rsp_span_base_in;
      rsp_span_length_ff <= rsp_span_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_span_length_ff, rsp_span_base_ff,
                        rsp_result_addr_ff, rsp_status_ff};

   // An accepted request always starts the span computation.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SPAN_SUM)
      else $error("accepted request did not start the sequencer");

   // The bitmap is never written while the block waits for a request.
   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_wr_en)
      else $error("bitmap written while idle");

   // A pending row check only exists during a scan.
   a_chk_in_scan : assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == ST_SCAN)
      else $error("row check outside of a scan");

   // Error responses carry all-zero result fields.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_OK |->
         rsp_result_addr_ff == '0 && rsp_span_base_ff == '0 && rsp_span_length_ff == '0)
      else $error("error response with non-zero fields");

   // A new response is only loaded once the previous one has been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !rsp_load)
      else $error("stalled response overwritten");

endmodule

// ----- bench/tb_io_window_slot_allocator_core.sv -----
// Self-checking bench for io_window_slot_allocator_core: directed plan, then random traffic.
// Depends on iwsa_pkg and the core RTL. Both slot bitmaps and the window base are mirrored
// here, so every response beat can be predicted.
module tb_io_window_slot_allocator_core;
   import iwsa_pkg::*;

   localparam int PG_SHIFT = PAGE_SHIFT_DEF;
   localparam int LG_SHIFT = PAGE_SHIFT_DEF + LARGE_SLOT_PAGE_SHIFT_DEF;
   localparam int N_SMALL = SMALL_SLOTS_DEF;
   localparam int N_LARGE = LARGE_SLOTS_DEF;
   localparam int PAGE_INT = 1 << PG_SHIFT;
   localparam int LARGE_INT = 1 << LG_SHIFT;
   localparam logic [ADDR_W-1:0] PAGE_MASK = 64'(PAGE_INT - 1);

   // Run-length guards. The watchdog allows many times the slowest legal run: at most 1133
   // request beats, each with its busy time plus random idle gaps on both sides.
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int FILL_CAP = 900;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   result_addr;
      logic [ADDR_W-1:0]   span_base;
      logic [SPAN_OUT_W-1:0] span_length;
   } slot_result_t;

   typedef enum logic {
      STEP_REQ = 1'b0,
      STEP_CSR = 1'b1
   } step_type;

   // One row of the directed plan. For a register step the new window base sits in virt.
   // Where known is set, want holds the result read straight off the spec; otherwise the
   // predictor decides.
   typedef struct {
      step_type          step;
      kind_type          kind;
      logic [PHYS_W-1:0] phys;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] virt;
      bit                known;
      slot_result_t      want;
   } plan_row_t;

   localparam slot_result_t PREDICTED = '0;
   localparam slot_result_t NO_SPACE_RESULT = '{STAT_NO_SPACE, 64'h0, 64'h0, 19'h0};
   localparam slot_result_t BAD_UNMAP_RESULT = '{STAT_BAD_UNMAP, 64'h0, 64'h0, 19'h0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ADDR_W-1:0]     csr_data = '0;

   // Mirror of the block's state: one bit per slot in each pool, plus the window base.
   bit                small_used [N_SMALL];
   bit                large_used [N_LARGE];
   logic [ADDR_W-1:0] window_base = WINDOW_BASE_RESET;

   slot_result_t pending_results [$];
   bit           failed = 1'b0;
   int           cycle_count = 0;
   bit           req_steady = 1'b0;
   bit           rsp_steady = 1'b0;

   // The plan starts from the reset base: the small region at ...FFA0_0000, the large
   // region right after it at ...FFC0_0000, ending exactly where the address space wraps.
   plan_row_t directed_plan [25] = '{
      // Zero length at an aligned address still claims small slot 0.
      '{STEP_REQ, KIND_MAP, 52'h0, 32'h0, 64'h0, 1'b1,
        '{STAT_OK, WINDOW_BASE_RESET, 64'h0, 19'h0}},
      // Highest physical address, one byte: the offset pushes the span to a full page.
      '{STEP_REQ, KIND_MAP, 52'hF_FFFF_FFFF_FFFF, 32'h1, 64'h0, 1'b1,
        '{STAT_OK, 64'hFFFF_FFFF_FFA0_1FFF, 64'h000F_FFFF_FFFF_F000, 19'h01000}},
      // Longest length: too long for any slot.
      '{STEP_REQ, KIND_MAP, 52'h1000, 32'hFFFF_FFFF, 64'h0, 1'b1, NO_SPACE_RESULT},
      // Exactly one large slot.
      '{STEP_REQ, KIND_MAP, 52'h0, 32'h4_0000, 64'h0, 1'b1,
        '{STAT_OK, 64'hFFFF_FFFF_FFC0_0000, 64'h0, 19'h40000}},
      '{STEP_REQ, KIND_MAP, 52'h1, 32'h3_FFFF, 64'h0, 1'b0, PREDICTED},
      // One byte past a large slot once the offset is added.
      '{STEP_REQ, KIND_MAP, 52'h800, 32'h3_F801, 64'h0, 1'b1, NO_SPACE_RESULT},
      '{STEP_REQ, KIND_MAP, 52'h5_A5A5_A5A5_A5A5, 32'h1001, 64'h0, 1'b0, PREDICTED},
      '{STEP_REQ, KIND_MAP, 52'hABC, 32'h544, 64'h0, 1'b0, PREDICTED},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h0, WINDOW_BASE_RESET, 1'b1,
        '{STAT_OK, WINDOW_BASE_RESET, WINDOW_BASE_RESET, 19'h0}},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h1, 64'hFFFF_FFFF_FFA0_1FFF, 1'b1,
        '{STAT_OK, 64'hFFFF_FFFF_FFA0_2000, 64'hFFFF_FFFF_FFA0_1000, 19'h01000}},
      // Slot 0 is already free here; the unmap is still accepted.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h1000, WINDOW_BASE_RESET, 1'b1,
        '{STAT_OK, 64'hFFFF_FFFF_FFA0_1000, WINDOW_BASE_RESET, 19'h01000}},
      // Below the window.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h0, 64'h0, 1'b1, BAD_UNMAP_RESULT},
      // Small region, but the span crosses into a second page.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h2, 64'hFFFF_FFFF_FFA0_0FFF, 1'b1, BAD_UNMAP_RESULT},
      // Large region, span longer than a large slot.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h4_0001, 64'hFFFF_FFFF_FFC0_0000, 1'b1,
        BAD_UNMAP_RESULT},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h100, 64'hFFFF_FFFF_FFC0_0005, 1'b1,
        '{STAT_OK, 64'hFFFF_FFFF_FFC0_1000, 64'hFFFF_FFFF_FFC0_0000, 19'h01000}},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        BAD_UNMAP_RESULT},
      // Last large slot; the end of the freed range wraps to zero.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{STAT_OK, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 19'h01000}},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h3FF, 64'h0001_2345_6789_ABCD, 1'b0, PREDICTED},
      // Window at address zero.
      '{STEP_CSR, KIND_MAP, 52'h0, 32'h0, 64'h0, 1'b0, PREDICTED},
      '{STEP_REQ, KIND_MAP, 52'hFFF, 32'h0, 64'h0, 1'b0, PREDICTED},
      // Decodes to large slot 16, one past the pool.
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h0, 64'h60_0000, 1'b1, BAD_UNMAP_RESULT},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h4_0000, 64'h24_0000, 1'b0, PREDICTED},
      // All-ones window base: unaligned, and every region address past the base itself wraps.
      '{STEP_CSR, KIND_MAP, 52'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, PREDICTED},
      '{STEP_REQ, KIND_MAP, 52'h0, 32'h1000, 64'h0, 1'b0, PREDICTED},
      '{STEP_REQ, KIND_UNMAP, 52'h0, 32'h0, 64'h0, 1'b1, BAD_UNMAP_RESULT}
   };

   io_window_slot_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // kind
      .req_tdata  (req_tdata),   // phys_addr, length, virt_addr, zero pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // status, result_addr, span_base, span_length, zero pad
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // window_base
   );

   always #6 clock = ~clock;

   // Predicts the response to one request and applies its effect to the mirrored bitmaps.
   // Errors leave both bitmaps alone and zero every field but the status.
   function automatic slot_result_t predict_slot_result(kind_type kind,
                                                        logic [PHYS_W-1:0] phys,
                                                        logic [LEN_W-1:0] len,
                                                        logic [ADDR_W-1:0] virt);
      slot_result_t      r;
      logic [ADDR_W-1:0] large_base;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] va;
      logic [ADDR_W-1:0] slot;
      bit                found;
      r = '0;
      va = '0;
      found = 1'b0;
      large_base = window_base + (64'(N_SMALL) << PG_SHIFT);
      if (kind == KIND_MAP) begin
         off = {12'd0, phys} & PAGE_MASK;
         start = {12'd0, phys} & ~PAGE_MASK;
         span = ({32'd0, len} + off + PAGE_MASK) & ~PAGE_MASK;
         // A page or less tries the small pool first; anything up to a large slot,
         // including a small request that found the small pool full, tries the large pool.
         if (span <= 64'(PAGE_INT)) begin
            for (int i = 0; i < N_SMALL; i++) begin
               if (!small_used[i]) begin
                  small_used[i] = 1'b1;
                  va = window_base + (64'(i) << PG_SHIFT);
                  found = 1'b1;
                  break;
               end
            end
         end
         if (!found && span <= 64'(LARGE_INT)) begin
            for (int i = 0; i < N_LARGE; i++) begin
               if (!large_used[i]) begin
                  large_used[i] = 1'b1;
                  va = large_base + (64'(i) << LG_SHIFT);
                  found = 1'b1;
                  break;
               end
            end
         end
         if (!found) begin
            r.status = STAT_NO_SPACE;
         end else begin
            r.status = STAT_OK;
            r.result_addr = va + off;
            r.span_base = start;
            r.span_length = span[SPAN_OUT_W-1:0];
         end
      end else begin
         off = virt & PAGE_MASK;
         start = virt & ~PAGE_MASK;
         span = ({32'd0, len} + off + PAGE_MASK) & ~PAGE_MASK;
         r.status = STAT_BAD_UNMAP;
         // Which pool is decided only by comparing against the large region base.
         if (start < large_base) begin
            if (start >= window_base && span <= 64'(PAGE_INT)) begin
               slot = (start - window_base) >> PG_SHIFT;
               if (slot < 64'(N_SMALL)) begin
                  small_used[slot] = 1'b0;
                  r.status = STAT_OK;
               end
            end
         end else if (span <= 64'(LARGE_INT)) begin
            slot = (start - large_base) >> LG_SHIFT;
            if (slot < 64'(N_LARGE)) begin
               large_used[slot] = 1'b0;
               r.status = STAT_OK;
            end
         end
         if (r.status == STAT_OK) begin
            r.result_addr = start + span;
            r.span_base = start;
            r.span_length = span[SPAN_OUT_W-1:0];
         end
      end
      return r;
   endfunction

   // Idle cycles before the next beat on one side. Now and then a side switches into a
   // stretch with no idling at all, so back-to-back beats get exercised too.
   function automatic int draw_gap(inout bit steady);
      if ($urandom_range(0, 31) == 0) begin
         steady = !steady;
      end
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic int free_small_slots();
      int n;
      n = 0;
      foreach (small_used[i]) begin
         if (!small_used[i]) n++;
      end
      return n;
   endfunction

   // Lowest-effort search for a slot that is in use, starting at a random place. When the
   // pool is empty the random slot is returned anyway, which unmaps a free slot.
   function automatic int pick_used_slot(bit from_large);
      int n;
      int first;
      n = from_large ? N_LARGE : N_SMALL;
      first = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
         if (from_large ? large_used[(first + k) % n] : small_used[(first + k) % n]) begin
            return (first + k) % n;
         end
      end
      return first;
   endfunction

   // Sends one request beat and records what the response must be. Valid stays high across
   // back-to-back beats; it is lowered only when an idle gap follows.
   task automatic send_request(kind_type kind, logic [PHYS_W-1:0] phys, logic [LEN_W-1:0] len,
                               logic [ADDR_W-1:0] virt, bit known, slot_result_t want);
      int           gap;
      slot_result_t predicted;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, virt, len, phys};
      do @(posedge clock); while (!req_tready);
      predicted = predict_slot_result(kind, phys, len, virt);
      pending_results.push_back(known ? want : predicted);
   endtask

   // The base register only changes while the block is idle: every response has come
   // back, and a short pause lets the sequencer settle.
   task automatic write_window_base(logic [ADDR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_base = value;
   endtask

   // One random request. Most are well formed: maps sized for the small or large pool and
   // unmaps aimed at slots that are currently held. The rest is arbitrary noise.
   task automatic issue_random(int map_pct, int large_pct, int noise_pct);
      int                roll;
      int                slot;
      int                off;
      bit                from_large;
      logic [PHYS_W-1:0] phys;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] virt;
      roll = $urandom_range(0, 99);
      phys = PHYS_W'({$urandom, $urandom});
      virt = {$urandom, $urandom};
      len = $urandom;
      if (roll < noise_pct) begin
         if ($urandom_range(0, 1)) len = len >> $urandom_range(0, 31);
         send_request($urandom_range(0, 1) ? KIND_UNMAP : KIND_MAP, phys, len, virt,
                      1'b0, PREDICTED);
      end else if (roll < noise_pct + map_pct) begin
         off = int'(phys[PG_SHIFT-1:0]);
         if ($urandom_range(0, 99) < large_pct) begin
            len = $urandom_range(PAGE_INT + 1 - off, LARGE_INT - off);
         end else begin
            len = $urandom_range(0, PAGE_INT - off);
         end
         send_request(KIND_MAP, phys, len, virt, 1'b0, PREDICTED);
      end else begin
         from_large = ($urandom_range(0, 99) < 30);
         slot = pick_used_slot(from_large);
         off = $urandom_range(0, PAGE_INT - 1);
         if (from_large) begin
            virt = window_base + (64'(N_SMALL) << PG_SHIFT) + (64'(slot) << LG_SHIFT)
                   + 64'(off);
            len = $urandom_range(0, LARGE_INT - off);
         end else begin
            virt = window_base + (64'(slot) << PG_SHIFT) + 64'(off);
            len = $urandom_range(0, PAGE_INT - off);
         end
         send_request(KIND_UNMAP, phys, len, virt, 1'b0, PREDICTED);
      end
   endtask

   // A phase of random traffic. With fill set it runs until the small pool is full or FILL_CAP
   // is hit, so later traffic spills into the large pool and then runs out of space.
   task automatic run_phase(int items, int map_pct, int large_pct, int noise_pct, bit fill);
      int n;
      n = 0;
      while (n < items || (fill && free_small_slots() != 0 && n < FILL_CAP)) begin
         issue_random(map_pct, large_pct, noise_pct);
         n++;
      end
   endtask

   // Response side: before each beat, ready drops for a random idle gap, which may be empty.
   initial begin : rsp_backpressure
      int gap;
      wait (!reset);
      forever begin
         gap = draw_gap(rsp_steady);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Every response beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : rsp_check
      slot_result_t got;
      slot_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.result_addr = rsp_tdata[65:2];
         got.span_base = rsp_tdata[129:66];
         got.span_length = rsp_tdata[148:130];
         if (pending_results.size() == 0) begin
            $error("response beat with nothing outstanding: status %0d", got.status);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               failed = 1'b1;
            end
            if (got.result_addr != want.result_addr) begin
               $error("result_addr: expected %h, got %h", want.result_addr, got.result_addr);
               failed = 1'b1;
            end
            if (got.span_base != want.span_base) begin
               $error("span_base: expected %h, got %h", want.span_base, got.span_base);
               failed = 1'b1;
            end
            if (got.span_length != want.span_length) begin
               $error("span_length: expected %h, got %h", want.span_length, got.span_length);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_io_window_slot_allocator_core: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The clearing pass after reset simply holds off the first handshake.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].step == STEP_CSR) begin
            write_window_base(directed_plan[i].virt);
         end else begin
            send_request(directed_plan[i].kind, directed_plan[i].phys, directed_plan[i].len,
                         directed_plan[i].virt, directed_plan[i].known, directed_plan[i].want);
         end
      end

      // Random page-aligned window, mixed traffic.
      write_window_base({$urandom, $urandom} & ~PAGE_MASK);
      run_phase(60, 50, 20, 10, 1'b0);

      // Back at the reset base: fill the small pool, then push on until the large pool
      // is full too and maps start to fail.
      write_window_base(WINDOW_BASE_RESET);
      run_phase(0, 93, 0, 3, 1'b1);
      run_phase(50, 70, 40, 10, 1'b0);

      // Large region base wraps past the top of the address space; unmap-heavy.
      write_window_base(64'hFFFF_FFFF_FFF0_0000);
      run_phase(50, 30, 20, 10, 1'b0);

      // Arbitrary, usually unaligned base.
      write_window_base({$urandom, $urandom});
      run_phase(50, 40, 30, 20, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("tb_io_window_slot_allocator_core: done, clean");
      end else begin
         $display("tb_io_window_slot_allocator_core: done, errors");
      end
      $finish;
   end

endmodule
